// ===== rtl/mbsp_pkg.sv =====
package mbsp_pkg;

    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_EOX     = 8'hF7;
    localparam logic [7:0] MTC_QUARTER   = 8'hF1;
    localparam logic [7:0] SONG_POSITION = 8'hF2;
    localparam logic [7:0] SONG_SELECT   = 8'hF3;
    localparam logic [7:0] COMMON_FIRST_DROP = 8'hF4;
    localparam logic [7:0] REALTIME_FIRST    = 8'hF8;
    localparam logic [7:0] UNDEF_RT_A    = 8'hF9;
    localparam logic [7:0] UNDEF_RT_B    = 8'hFD;
    localparam logic [7:0] SYSTEM_FIRST  = 8'hF0;
    localparam logic [7:0] NO_STATUS     = 8'h00;

    localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS  = 4'hD;

    localparam logic [1:0] FILL_NONE   = 2'd0;
    localparam logic [1:0] FILL_FIRST  = 2'd1;
    localparam logic [1:0] FILL_SECOND = 2'd2;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [1:0] msg_length;
    } mbsp_msg_t;

    typedef struct packed {
        logic      emit;
        mbsp_msg_t msg;
    } mbsp_result_t;

endpackage

// ===== rtl/mbsp_core.sv =====
module mbsp_core
    import mbsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   in_byte,
    output mbsp_result_t result
);

    logic       in_sysex_reg,    in_sysex_next;
    logic [7:0] held_status_reg, held_status_next;
    logic [6:0] held_data_reg,   held_data_next;
    logic [1:0] fill_index_reg,  fill_index_next;

    logic need_two;

    // Program change, channel pressure, MTC quarter frame and song select carry one data byte.
    assign need_two = (held_status_reg[7:4] == NIB_PROG_CHANGE)
                   || (held_status_reg[7:4] == NIB_CHAN_PRESS)
                   || (held_status_reg == MTC_QUARTER)
                   || (held_status_reg == SONG_SELECT);

    always_comb begin
        in_sysex_next    = in_sysex_reg;
        held_status_next = held_status_reg;
        held_data_next   = held_data_reg;
        fill_index_next  = fill_index_reg;
        result           = '0;

        if (in_byte == SYSEX_START) begin
            in_sysex_next = 1'b1;
        end else if (in_byte == SYSEX_EOX) begin
            in_sysex_next = 1'b0;
        end else if (in_sysex_reg) begin
            // drop everything inside sysex
        end else if (in_byte >= REALTIME_FIRST) begin
            if (in_byte != UNDEF_RT_A && in_byte != UNDEF_RT_B) begin
                result.emit            = 1'b1;
                result.msg.status_byte = in_byte;
                result.msg.msg_length  = LEN_ONE;
            end
        end else if (in_byte >= COMMON_FIRST_DROP) begin
            // drop undefined and tune request common bytes
        end else if (in_byte[7]) begin
            held_status_next = in_byte;
            fill_index_next  = FILL_FIRST;
        end else if (held_status_reg != NO_STATUS) begin
            if (fill_index_reg != FILL_SECOND && !need_two) begin
                held_data_next  = in_byte[6:0];
                fill_index_next = FILL_SECOND;
            end else begin
                result.emit            = 1'b1;
                result.msg.status_byte = held_status_reg;
                if (fill_index_reg != FILL_SECOND) begin
                    result.msg.data_first = in_byte[6:0];
                    result.msg.msg_length = LEN_TWO;
                end else begin
                    result.msg.data_first  = held_data_reg;
                    result.msg.data_second = in_byte[6:0];
                    result.msg.msg_length  = LEN_THREE;
                end
                held_data_next = '0;
                // System common clears status; channel messages keep running status.
                if (held_status_reg >= SYSTEM_FIRST) begin
                    held_status_next = NO_STATUS;
                    fill_index_next  = FILL_NONE;
                end else begin
                    fill_index_next  = FILL_FIRST;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sysex_reg    <= 1'b0;
            held_status_reg <= NO_STATUS;
            held_data_reg   <= '0;
            fill_index_reg  <= FILL_NONE;
        end else if (step) begin
            in_sysex_reg    <= in_sysex_next;
            held_status_reg <= held_status_next;
            held_data_reg   <= held_data_next;
            fill_index_reg  <= fill_index_next;
        end
    end

endmodule

// ===== rtl/midi_byte_stream_parser.sv =====
// Channel | Direction | Ports                                          | Role
// s_      | in        | s_valid, s_ready, s_in_byte                    | received MIDI byte
// m_      | out       | m_valid, m_ready, m_status_byte, m_data_first, | completed message
//         |           | m_data_second, m_msg_length                    |
//
// One byte is taken per cycle unless a byte that completes a message waits on a full
// result register; a completed message passes through the input register, then the result
// register, and is held there while the result register waits on m_ready.
// The parser state updates in the cycle a byte leaves the input register, which sets
// the one-byte-per-cycle rate.
// aresetn is synchronous, active low: it empties both registers and clears the state.
// While a result waits on m_ready, the input register still takes one more byte; bytes
// that complete no message keep flowing through it.
module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_status_byte,
    output logic [6:0] m_data_first,
    output logic [6:0] m_data_second,
    output logic [1:0] m_msg_length
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    mbsp_msg_t    out_msg_reg;
    mbsp_result_t result;
    logic         out_free;
    logic         advance;

    // The result register can take a new message when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;

    // Advance the held byte unless it makes a message and the result register is full.
    assign advance = in_valid_reg && (!result.emit || out_free);

    assign s_ready = !in_valid_reg || advance;

    mbsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_byte (in_byte_reg),
        .result  (result)
    );

    // Input register: hold the byte until the parser consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // Result register: load a finished message, drop valid once transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && result.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            out_msg_reg <= result.msg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status_byte = out_msg_reg.status_byte;
    assign m_data_first  = out_msg_reg.data_first;
    assign m_data_second = out_msg_reg.data_second;
    assign m_msg_length  = out_msg_reg.msg_length;

endmodule

// ===== rtl/mbsp_checker.sv =====
module mbsp_checker
    import mbsp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_status_byte,
    input logic [6:0] m_data_first,
    input logic [6:0] m_data_second,
    input logic [1:0] m_msg_length
);

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status_byte)
            && $stable(m_data_first) && $stable(m_data_second) && $stable(m_msg_length))
        else $error("stalled result changed");

    // Every message starts with a status byte and has a length.
    a_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status_byte[7] && m_msg_length != 2'd0)
        else $error("malformed message");

    // One-byte messages are realtime with cleared data.
    a_realtime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msg_length == LEN_ONE |->
            m_status_byte >= REALTIME_FIRST && m_data_first == 7'd0 && m_data_second == 7'd0)
        else $error("bad one-byte message");

    // Two-byte messages leave the second data byte zero.
    a_two_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msg_length == LEN_TWO |->
            m_data_second == 7'd0 && m_status_byte < REALTIME_FIRST)
        else $error("bad two-byte message");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status_byte (m_status_byte),
    .m_data_first  (m_data_first),
    .m_data_second (m_data_second),
    .m_msg_length  (m_msg_length)
);

// ===== tb/tb.sv =====
module tb;
    import mbsp_pkg::*;

    // Status nibbles and system bytes the stimulus builds on top of the package codes
    localparam logic [3:0] NIB_NOTE_OFF    = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON     = 4'h9;
    localparam logic [3:0] NIB_CTRL_CHANGE = 4'hB;
    localparam logic [3:0] NIB_PITCH_BEND  = 4'hE;
    localparam logic [7:0] RT_TIMING_CLOCK = 8'hF8;
    localparam logic [7:0] RT_START        = 8'hFA;
    localparam logic [7:0] RT_RESET        = 8'hFF;
    localparam logic [7:0] UNDEF_COMMON    = 8'hF5;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_status_byte;
    logic [6:0] m_data_first;
    logic [6:0] m_data_second;
    logic [1:0] m_msg_length;

    // Parser state mirrored on the testbench side
    logic       in_sysex_q;
    logic [7:0] status_q;
    logic [6:0] data_q;
    logic [1:0] fill_q;
    mbsp_msg_t  msg_expected[$];
    mbsp_msg_t  msg_want;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_used;
    int fail_count;
    int hold_requests;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    midi_byte_stream_parser u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status_byte (m_status_byte),
        .m_data_first  (m_data_first),
        .m_data_second (m_data_second),
        .m_msg_length  (m_msg_length)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Advance the parser mirror by one byte; queue the message it completes.
    // Return high when the byte did anything at all (state change or message).
    function automatic logic parse_byte(input logic [7:0] b);
        mbsp_msg_t m;
        logic      two_byte;
        m = '0;
        if (b == SYSEX_START) begin
            in_sysex_q = 1'b1;
            return 1'b1;
        end
        if (b == SYSEX_EOX) begin
            in_sysex_q = 1'b0;
            return 1'b1;
        end
        if (in_sysex_q)
            return 1'b0;
        if (b >= REALTIME_FIRST) begin
            if (b == UNDEF_RT_A || b == UNDEF_RT_B)
                return 1'b0;
            m.status_byte = b;
            m.msg_length  = LEN_ONE;
            msg_expected.push_back(m);
            return 1'b1;
        end
        if (b >= COMMON_FIRST_DROP)
            return 1'b0;
        if (b[7]) begin
            status_q = b;
            fill_q   = FILL_FIRST;
            return 1'b1;
        end
        // data byte: dropped while no status is held
        if (status_q == NO_STATUS)
            return 1'b0;
        two_byte = status_q[7:4] == NIB_PROG_CHANGE || status_q[7:4] == NIB_CHAN_PRESS
            || status_q == MTC_QUARTER || status_q == SONG_SELECT;
        m.status_byte = status_q;
        if (fill_q == FILL_SECOND) begin
            m.data_first  = data_q;
            m.data_second = b[6:0];
            m.msg_length  = LEN_THREE;
        end else if (two_byte) begin
            m.data_first = b[6:0];
            m.msg_length = LEN_TWO;
        end else begin
            data_q = b[6:0];
            fill_q = FILL_SECOND;
            return 1'b1;
        end
        msg_expected.push_back(m);
        data_q = '0;
        // system common clears the held status; channel status keeps running
        if (status_q >= SYSTEM_FIRST) begin
            status_q = NO_STATUS;
            fill_q   = FILL_NONE;
        end else begin
            fill_q = FILL_FIRST;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // Offer one byte, hold it until the transfer, then update the mirror
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (parse_byte(b))
            bytes_used++;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every message transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (msg_expected.size() == 0) begin
                report_mismatch("unexpected message, status", m_status_byte, NO_STATUS);
            end else begin
                msg_want = msg_expected.pop_front();
                if (m_status_byte !== msg_want.status_byte)
                    report_mismatch("status_byte", m_status_byte, msg_want.status_byte);
                if (m_data_first !== msg_want.data_first)
                    report_mismatch("data_first", 8'(m_data_first),
                                    8'(msg_want.data_first));
                if (m_data_second !== msg_want.data_second)
                    report_mismatch("data_second", 8'(m_data_second),
                                    8'(msg_want.data_second));
                if (m_msg_length !== msg_want.msg_length)
                    report_mismatch("msg_length", 8'(m_msg_length),
                                    8'(msg_want.msg_length));
            end
        end
    end

    // Drop the run when neither channel has moved for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic test_orphan_data();
        send_byte(8'h00);
    endtask

    // Note on at the data extremes, then a second message on running status
    task automatic test_running_status();
        send_byte({NIB_NOTE_ON, 4'h0});
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte(8'h00);
    endtask

    // Realtime between data bytes goes out at once; undefined realtime vanishes
    task automatic test_realtime_interleave();
        send_byte(8'h11);
        send_byte(RT_START);
        send_byte(8'h22);
        send_byte(UNDEF_RT_A);
        send_byte(UNDEF_RT_B);
    endtask

    // A new status cuts the pending message; one-byte common keeps the status
    task automatic test_status_change();
        send_byte({NIB_CTRL_CHANGE, 4'hF});
        send_byte(8'h05);
        send_byte({NIB_CHAN_PRESS, 4'h3});
        send_byte(8'h7F);
        send_byte(UNDEF_COMMON);
        send_byte(8'h40);
    endtask

    // System common completes once, then trailing data is orphaned
    task automatic test_system_common();
        send_byte(MTC_QUARTER);
        send_byte(8'h01);
        send_byte(SONG_POSITION);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
    endtask

    // Everything inside sysex is swallowed, realtime included
    task automatic test_sysex();
        send_byte({NIB_PITCH_BEND, 4'h0});
        send_byte(SYSEX_START);
        send_byte(RT_TIMING_CLOCK);
        send_byte(8'h01);
        send_byte(SYSEX_EOX);
        send_byte(RT_RESET);
    endtask

    // Mostly well-formed messages with random content, plus noise and broken ones
    task automatic test_random_traffic(input int target);
        int         first_count;
        int         pick;
        int         need;
        int         k;
        logic [7:0] running;
        logic [7:0] common;
        first_count = bytes_used;
        running     = NO_STATUS;
        while (bytes_used - first_count < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                if (running == NO_STATUS || $urandom_range(2) == 0) begin
                    running = {4'($urandom_range(NIB_NOTE_OFF, NIB_PITCH_BEND)),
                               4'($urandom_range(15))};
                    send_byte(running);
                end
                need = (running[7:4] == NIB_PROG_CHANGE || running[7:4] == NIB_CHAN_PRESS)
                    ? 1 : 2;
                if ($urandom_range(9) == 0)
                    need = need - 1;
                for (k = 0; k < need; k++) begin
                    if ($urandom_range(9) == 0)
                        send_byte(REALTIME_FIRST | 8'($urandom_range(7)));
                    send_byte(8'($urandom_range(127)));
                end
            end else if (pick < 70) begin
                case ($urandom_range(2))
                    0: common = MTC_QUARTER;
                    1: common = SONG_SELECT;
                    default: common = SONG_POSITION;
                endcase
                send_byte(common);
                send_byte(8'($urandom_range(127)));
                if (common == SONG_POSITION)
                    send_byte(8'($urandom_range(127)));
                running = NO_STATUS;
            end else if (pick < 80) begin
                send_byte(REALTIME_FIRST | 8'($urandom_range(7)));
            end else if (pick < 85) begin
                send_byte(SYSEX_START);
                repeat ($urandom_range(6))
                    send_byte(8'($urandom_range(255)));
                send_byte(SYSEX_EOX);
            end else if (pick < 90) begin
                send_byte(COMMON_FIRST_DROP + 8'($urandom_range(2)));
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Hold the receiver off while note messages keep coming, so the input stalls
    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        send_byte({NIB_NOTE_ON, 4'($urandom_range(15))});
        repeat (40)
            send_byte(8'($urandom_range(127)));
    endtask

    initial begin
        in_sysex_q    = 1'b0;
        status_q      = NO_STATUS;
        data_q        = '0;
        fill_q        = FILL_NONE;
        bytes_used    = 0;
        fail_count    = 0;
        hold_requests = 0;
        send_idle_pct = 38;
        recv_idle_pct = 65;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_orphan_data();
        test_running_status();
        test_realtime_interleave();
        test_status_change();
        test_system_common();
        test_sysex();
        test_random_traffic(400);

        send_idle_pct = 65;
        recv_idle_pct = 38;
        test_random_traffic(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(400);
        test_backpressure();

        // Drain: wait for every expected message before the verdict
        s_valid <= 1'b0;
        while (msg_expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
